### hw/rtl/empirical_semivariogram_unit_assert.svh
// ----------------------------------------------------------------------------
// Semivariogram unit assertion macros
// Concurrent checks clocked on clock and masked while reset is high.
// ----------------------------------------------------------------------------
`ifndef EMPIRICAL_SEMIVARIOGRAM_UNIT_ASSERT_SVH
`define EMPIRICAL_SEMIVARIOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define ESU_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("semivariogram unit check failed");

// Next-cycle implication, masked during reset.
`define ESU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("semivariogram unit check failed");

`endif

### hw/rtl/esu_pkg.sv
// ----------------------------------------------------------------------------
// Semivariogram unit package
// Shared widths, operation codes and register addresses.
// ----------------------------------------------------------------------------
package esu_pkg;

   localparam int ESU_MAX_POINTS = 256;
   localparam int ESU_COORD_W    = 16;
   localparam int ESU_Z_W        = 24;
   localparam int ESU_LAG_W      = 12;
   localparam int ESU_SV_W       = 48;
   localparam int ESU_PC_W       = 15;
   localparam int ESU_ADDR_W     = 3;
   localparam int ESU_DATA_W     = 32;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // register index taken from the word address bit
   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic REG_PEDESTAL  = 1'b1;

endpackage

### hw/rtl/empirical_semivariogram_unit.sv
// ----------------------------------------------------------------------------
// Empirical semivariogram unit
// Point store with a pairwise lag-window semivariance query.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one operation per transfer: load a point, clear the
//    store or query a lag. Loads and clears complete in the cycle of their
//    transfer and the unit is ready again on the next cycle.
//  - A query walks all n*(n-1)/2 unordered pairs of the n stored points with
//    one shared squaring multiplier, fetching each outer point before its
//    pairs. If any pair lies in the window, it then runs a restoring divide
//    of one quotient bit per cycle. req_ready stays low from the query's
//    transfer until its result is placed in the output register.
//  - rsp_ channel delivers one result per query from an output register. A
//    new item may be taken while that result still waits; a later query
//    holds in its final step until the previous result has been taken.
//  - Configuration side is an APB-style port: tolerance at byte 0,
//    pedestal_mode at byte 4; write it only while the unit is idle.
//  - Synchronous reset empties the store, clears the pedestal, the
//    registers and any pending result. Store contents are not cleared.
// ----------------------------------------------------------------------------
module empirical_semivariogram_unit #(
   parameter int MAX_POINTS = esu_pkg::ESU_MAX_POINTS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_operation,
   input  logic signed [esu_pkg::ESU_COORD_W-1:0] req_x_pos,
   input  logic signed [esu_pkg::ESU_COORD_W-1:0] req_y_pos,
   input  logic signed [esu_pkg::ESU_Z_W-1:0]     req_z_value,
   input  logic [esu_pkg::ESU_LAG_W-1:0]         req_lag,
   input  logic                                  req_list_start,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [esu_pkg::ESU_SV_W-1:0]    rsp_semivariance,
   output logic [esu_pkg::ESU_PC_W-1:0]          rsp_pair_count,
   output logic                                  rsp_empty_bin,
   // configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [esu_pkg::ESU_ADDR_W-1:0]        paddr,
   input  logic [esu_pkg::ESU_DATA_W-1:0]        pwdata,
   output logic [esu_pkg::ESU_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import esu_pkg::*;

   localparam int IDX_W   = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int PAIR_W  = $clog2(MAX_POINTS * (MAX_POINTS - 1) / 2 + 1);
   localparam int SUM_W   = 2 * ESU_Z_W + PAIR_W;
   localparam int DIV_W   = $clog2(SUM_W);
   localparam int PCX_W   = (PAIR_W > ESU_PC_W) ? PAIR_W : ESU_PC_W;
   localparam int ENT_W   = 2 * ESU_COORD_W + ESU_Z_W;
   localparam int OPND_W  = ESU_Z_W + 1;
   localparam int PROD_W  = 2 * OPND_W;
   localparam int D2_W    = 2 * ESU_COORD_W + 2;
   localparam int BND_W   = 2 * (ESU_LAG_W + 5) + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BND_LO, ST_BND_HI, ST_RD_I, ST_CAP_I,
      ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_ACC, ST_DIV, ST_DONE
   } state_type;

   // point store: {x, y, z}
   logic [ENT_W-1:0] store_mem [MAX_POINTS];
   logic [ENT_W-1:0] rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        i_ff, i_in, j_ff, j_in;
   logic [ENT_W-1:0]        pi_ff, pi_in;
   logic [ESU_LAG_W-1:0]    lag_ff, lag_in;
   logic                    start_ff, start_in;
   logic [BND_W-1:0]        lo2_ff, lo2_in, hi2_ff, hi2_in;
   logic [D2_W-1:0]         d2_ff, d2_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [PAIR_W-1:0]       pairs_ff, pairs_in;
   logic [PAIR_W+1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]        dcnt_ff, dcnt_in;
   logic [ESU_SV_W-1:0]     ped_ff, ped_in;
   logic [ESU_LAG_W-1:0]    tol_ff, tol_in;
   logic                    mode_ff, mode_in;
   logic                    rv_ff, rv_in;
   logic [ESU_SV_W-1:0]     rsv_ff, rsv_in;
   logic [ESU_PC_W-1:0]     rpc_ff, rpc_in;
   logic                    reb_ff, reb_in;

   // shared squaring unit and datapath helpers
   logic [OPND_W-1:0]            mul_op;
   logic [PROD_W-1:0]            sq;
   logic signed [ESU_LAG_W:0]    lo_s, hi_s;
   logic signed [ESU_COORD_W:0]  dx, dy;
   logic signed [ESU_Z_W:0]      dz;
   logic [PAIR_W+1:0]            rem_sh, divisor;
   logic [PCX_W-1:0]             pairs_x;
   logic [ESU_SV_W-1:0]          raw, ped_eff;
   logic                         csr_wr, req_xfer;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rv_ff;
   assign rsp_semivariance = rsv_ff;
   assign rsp_pair_count   = rpc_ff;
   assign rsp_empty_bin    = reb_ff;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_PEDESTAL) ? {{(ESU_DATA_W-1){1'b0}}, mode_ff}
                                              : {{(ESU_DATA_W-ESU_LAG_W){1'b0}}, tol_ff};

   assign mem_we = req_xfer && (req_operation == OP_LOAD) && (req_z_value != '0)
                   && (count_ff < CNT_W'(MAX_POINTS));

   // the one multiplier, squaring whatever operand the sequencer selects
   assign sq = mul_op * mul_op;

   // write loaded points into the store; hold the fetched entry while its pair is squared
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[count_ff[IDX_W-1:0]] <= {req_x_pos, req_y_pos, req_z_value};
      end
      rd_ff <= store_mem[rd_addr];
   end

   always_comb begin
      lo_s = $signed({1'b0, lag_ff}) - $signed({1'b0, tol_ff});
      hi_s = $signed({1'b0, lag_ff}) + $signed({1'b0, tol_ff});
      dx = $signed({pi_ff[ENT_W-1], pi_ff[ENT_W-1 -: ESU_COORD_W]})
         - $signed({rd_ff[ENT_W-1], rd_ff[ENT_W-1 -: ESU_COORD_W]});
      dy = $signed({pi_ff[ESU_Z_W+ESU_COORD_W-1], pi_ff[ESU_Z_W +: ESU_COORD_W]})
         - $signed({rd_ff[ESU_Z_W+ESU_COORD_W-1], rd_ff[ESU_Z_W +: ESU_COORD_W]});
      dz = $signed({pi_ff[ESU_Z_W-1], pi_ff[ESU_Z_W-1:0]})
         - $signed({rd_ff[ESU_Z_W-1], rd_ff[ESU_Z_W-1:0]});
      case (state_ff)
         ST_BND_LO: mul_op = OPND_W'({lo_s[ESU_LAG_W-1:0], 4'b0000});
         ST_BND_HI: mul_op = OPND_W'({hi_s, 4'b0000});
         ST_SQ_X:   mul_op = OPND_W'(dx[ESU_COORD_W] ? -dx : dx);
         ST_SQ_Y:   mul_op = OPND_W'(dy[ESU_COORD_W] ? -dy : dy);
         ST_SQ_Z:   mul_op = OPND_W'(dz[ESU_Z_W] ? -dz : dz);
         default:   mul_op = '0;
      endcase
   end

   always_comb begin
      divisor = {1'b0, pairs_ff, 1'b0};
      rem_sh  = {rem_ff[PAIR_W:0], sum_ff[SUM_W-1]};
      pairs_x = PCX_W'(pairs_ff);
      raw     = (pairs_ff == '0) ? '0 : sum_ff[ESU_SV_W-1:0];
      ped_eff = start_ff ? raw : ped_ff;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      pi_in    = pi_ff;
      lag_in   = lag_ff;
      start_in = start_ff;
      lo2_in   = lo2_ff;
      hi2_in   = hi2_ff;
      d2_in    = d2_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      pairs_in = pairs_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      ped_in   = ped_ff;
      tol_in   = tol_ff;
      mode_in  = mode_ff;
      rv_in    = rv_ff && !rsp_ready;
      rsv_in   = rsv_ff;
      rpc_in   = rpc_ff;
      reb_in   = reb_ff;
      rd_addr  = i_ff[IDX_W-1:0];

      if (csr_wr) begin
         if (paddr[2] == REG_TOLERANCE) begin
            tol_in = pwdata[ESU_LAG_W-1:0];
         end else begin
            mode_in = pwdata[0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_operation)
                  OP_LOAD: begin
                     if (mem_we) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_CLEAR: count_in = '0;
                  OP_QUERY: begin
                     lag_in   = req_lag;
                     start_in = req_list_start;
                     sum_in   = '0;
                     pairs_in = '0;
                     i_in     = '0;
                     state_in = ST_BND_LO;
                  end
                  default: ;
               endcase
            end
         end
         ST_BND_LO: begin
            // lower bound only binds when lag - tolerance is positive
            lo2_in   = (lo_s > 0) ? sq[BND_W-1:0] : '0;
            state_in = ST_BND_HI;
         end
         ST_BND_HI: begin
            hi2_in   = sq[BND_W-1:0];
            state_in = (count_ff < CNT_W'(2)) ? ST_DONE : ST_RD_I;
         end
         ST_RD_I: state_in = ST_CAP_I;
         ST_CAP_I: begin
            pi_in    = rd_ff;
            j_in     = i_ff + 1'b1;
            rd_addr  = j_in[IDX_W-1:0];
            state_in = ST_SQ_X;
         end
         ST_SQ_X: begin
            rd_addr  = j_ff[IDX_W-1:0];
            prod_in  = sq;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            rd_addr  = j_ff[IDX_W-1:0];
            d2_in    = D2_W'(prod_ff);
            prod_in  = sq;
            state_in = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            rd_addr  = j_ff[IDX_W-1:0];
            d2_in    = d2_ff + D2_W'(prod_ff);
            prod_in  = sq;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if ((BND_W'(d2_ff) >= lo2_ff) && (BND_W'(d2_ff) < hi2_ff)) begin
               sum_in   = sum_ff + SUM_W'(prod_ff[2*ESU_Z_W-1:0]);
               pairs_in = pairs_ff + 1'b1;
            end
            j_in    = j_ff + 1'b1;
            rd_addr = j_in[IDX_W-1:0];
            if ({1'b0, j_ff} + (CNT_W+1)'(1) < {1'b0, count_ff}) begin
               state_in = ST_SQ_X;
            end else if ({1'b0, i_ff} + (CNT_W+1)'(2) < {1'b0, count_ff}) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_RD_I;
            end else begin
               rem_in   = '0;
               dcnt_in  = DIV_W'(SUM_W - 1);
               state_in = (pairs_in == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle, quotient shifts into the sum register
            if (rem_sh >= divisor) begin
               rem_in = rem_sh - divisor;
               sum_in = {sum_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               sum_in = {sum_ff[SUM_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rv_ff || rsp_ready) begin
               if (start_ff) begin
                  ped_in = raw;
               end
               rv_in    = 1'b1;
               rsv_in   = raw - (mode_ff ? ped_eff : '0);
               rpc_in   = (pairs_x > PCX_W'(32767)) ? ESU_PC_W'(32767)
                                                    : pairs_x[ESU_PC_W-1:0];
               reb_in   = (pairs_ff == '0);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ped_ff   <= '0;
         tol_ff   <= '0;
         mode_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ped_ff   <= ped_in;
         tol_ff   <= tol_in;
         mode_ff  <= mode_in;
         rv_ff    <= rv_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      pi_ff    <= pi_in;
      lag_ff   <= lag_in;
      start_ff <= start_in;
      lo2_ff   <= lo2_in;
      hi2_ff   <= hi2_in;
      d2_ff    <= d2_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      pairs_ff <= pairs_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      rsv_ff   <= rsv_in;
      rpc_ff   <= rpc_in;
      reb_ff   <= reb_in;
   end

endmodule

### hw/rtl/esu_checker.sv
// ----------------------------------------------------------------------------
// Semivariogram unit checker
// Port-level checks on handshake and result consistency.
// ----------------------------------------------------------------------------
`include "empirical_semivariogram_unit_assert.svh"

module esu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_operation,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [esu_pkg::ESU_SV_W-1:0]      rsp_semivariance,
   input logic [esu_pkg::ESU_PC_W-1:0]      rsp_pair_count,
   input logic                              rsp_empty_bin
);
   import esu_pkg::*;

   // stalled result holds
   `ESU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_semivariance))
   // empty flag agrees with the count
   `ESU_ASSERT_NOW(a_empty_cnt, rsp_valid, rsp_empty_bin == (rsp_pair_count == '0))
   // a query occupies the unit
   `ESU_ASSERT_NEXT(a_query_busy, req_valid && req_ready && req_operation == OP_QUERY, !req_ready)
   // loads, clears and unused operations finish at once
   `ESU_ASSERT_NEXT(a_quick_ops, req_valid && req_ready && req_operation != OP_QUERY, req_ready)

endmodule

bind empirical_semivariogram_unit esu_checker u_esu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_semivariance (rsp_semivariance),
   .rsp_pair_count   (rsp_pair_count),
   .rsp_empty_bin    (rsp_empty_bin)
);

### tb/empirical_semivariogram_unit_test.sv
// ----------------------------------------------------------------------------
// Semivariogram unit regression
// Drives loads, clears and lag queries with random idling on both channels,
// predicts every query result from a behavioural copy of the point store and
// checks each response transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module empirical_semivariogram_unit_test;
   import esu_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 400000;
   localparam int         RANDOM_ITEMS = 100;

   // one predicted query answer
   typedef struct {
      logic [ESU_SV_W-1:0] semivariance;
      logic [ESU_PC_W-1:0] pair_count;
      logic                empty_bin;
   } lag_answer_type;

   // Behavioural point store plus the queue of answers still owed by the unit.
   class semivariance_scoreboard;
      int                  xs [ESU_MAX_POINTS];
      int                  ys [ESU_MAX_POINTS];
      int                  zs [ESU_MAX_POINTS];
      int                  stored;
      logic [ESU_SV_W-1:0] pedestal = '0;
      int                  tolerance;
      bit                  pedestal_mode;
      lag_answer_type      owed [$];
      int                  errors;

      function void set_register(logic reg_index, int value);
         if (reg_index == REG_TOLERANCE) tolerance = value & 12'hFFF;
         else pedestal_mode = bit'(value & 1);
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // Update the store, and for a query work out the answer it will produce.
      function void note_request(logic [1:0] op, logic signed [ESU_COORD_W-1:0] x,
                                 logic signed [ESU_COORD_W-1:0] y,
                                 logic signed [ESU_Z_W-1:0] z,
                                 logic [ESU_LAG_W-1:0] lag, logic list_start);
         longint      lo, hi, lo2, hi2, dx, dy, dz, d2, pairs;
         logic [127:0] sum;
         logic [ESU_SV_W-1:0] raw;
         lag_answer_type ans;
         case (op)
            OP_LOAD: begin
               if (z != 0 && stored < ESU_MAX_POINTS) begin
                  xs[stored] = x;
                  ys[stored] = y;
                  zs[stored] = z;
                  stored++;
               end
            end
            OP_CLEAR: stored = 0;
            OP_QUERY: begin
               // bounds squared in Q12.4 units
               lo  = longint'(lag) - tolerance;
               hi  = longint'(lag) + tolerance;
               lo2 = lo > 0 ? (lo * 16) * (lo * 16) : 0;
               hi2 = (hi * 16) * (hi * 16);
               sum = '0;
               pairs = 0;
               for (int i = 0; i < stored; i++)
                  for (int j = i + 1; j < stored; j++) begin
                     dx = longint'(xs[i]) - xs[j];
                     dy = longint'(ys[i]) - ys[j];
                     d2 = dx * dx + dy * dy;
                     if (d2 >= lo2 && d2 < hi2) begin
                        dz = longint'(zs[i]) - zs[j];
                        sum += 128'(dz * dz);
                        pairs++;
                     end
                  end
               raw = '0;
               if (pairs != 0) raw = ESU_SV_W'(sum / 128'(2 * pairs));
               if (list_start) pedestal = raw;
               ans.semivariance = pedestal_mode ? raw - pedestal : raw;
               ans.pair_count   = pairs > 32767 ? 15'h7FFF : ESU_PC_W'(pairs);
               ans.empty_bin    = (pairs == 0);
               owed.insert(owed.size(), ans);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [ESU_SV_W-1:0] sv, logic [ESU_PC_W-1:0] pc,
                                 logic eb);
         lag_answer_type exp_ans;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result sv=%0d pairs=%0d empty=%0b", $time,
                     $signed(sv), pc, eb);
            errors++;
            return;
         end
         exp_ans = owed.pop_front();
         if (sv !== exp_ans.semivariance) begin
            $display("%0t: semivariance expected %0d actual %0d", $time,
                     $signed(exp_ans.semivariance), $signed(sv));
            errors++;
         end
         if (pc !== exp_ans.pair_count) begin
            $display("%0t: pair_count expected %0d actual %0d", $time,
                     exp_ans.pair_count, pc);
            errors++;
         end
         if (eb !== exp_ans.empty_bin) begin
            $display("%0t: empty_bin expected %0b actual %0b", $time,
                     exp_ans.empty_bin, eb);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_operation = OP_LOAD;
   logic signed [ESU_COORD_W-1:0] req_x_pos = '0;
   logic signed [ESU_COORD_W-1:0] req_y_pos = '0;
   logic signed [ESU_Z_W-1:0]     req_z_value = '0;
   logic [ESU_LAG_W-1:0]          req_lag = '0;
   logic                          req_list_start = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [ESU_SV_W-1:0]    rsp_semivariance;
   logic [ESU_PC_W-1:0]           rsp_pair_count;
   logic                          rsp_empty_bin;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [ESU_ADDR_W-1:0]         paddr = '0;
   logic [ESU_DATA_W-1:0]         pwdata = '0;
   logic [ESU_DATA_W-1:0]         prdata;
   logic                          pready;

   semivariance_scoreboard sb = new();
   bit idle_on = 1'b1;
   int stall_cycles = 0;
   int sent = 0;

   empirical_semivariogram_unit i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Check every response transfer at the edge where it happens.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_semivariance, rsp_pair_count, rsp_empty_bin);

   // Watchdog: count cycles with no transfer on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable && pwrite && pready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("empirical_semivariogram_unit regression: fail");
         $finish;
      end
   end

   // Receiver: bursts of stall or of readiness in random order; never stall late on.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         n = $urandom_range(1, 18);
         rsp_ready = !(idle_on && $urandom_range(0, 2) == 0);
         repeat (n - 1) @(negedge clock);
      end
   end

   // Present one item, possibly after an idle burst, and hold until transfer.
   task automatic send_item(logic [1:0] op, logic signed [ESU_COORD_W-1:0] x,
                            logic signed [ESU_COORD_W-1:0] y,
                            logic signed [ESU_Z_W-1:0] z, logic [ESU_LAG_W-1:0] lag,
                            logic list_start);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_operation  = op;
      req_x_pos      = x;
      req_y_pos      = y;
      req_z_value    = z;
      req_lag        = lag;
      req_list_start = list_start;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, x, y, z, lag, list_start);
      sent++;
      @(negedge clock);
   endtask

   task automatic release_channel();
      req_valid = 1'b0;
   endtask

   // Drain every owed answer, then allow the unit to settle before a write.
   task automatic wait_idle();
      release_channel();
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic reg_index, int value);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = {reg_index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      sb.set_register(reg_index, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   function automatic logic signed [ESU_COORD_W-1:0] rand_coord();
      // mostly within ten units so that lag windows catch pairs
      if ($urandom_range(0, 4) == 0) return ESU_COORD_W'($urandom);
      return ESU_COORD_W'($urandom_range(0, 320)) - 16'sd160;
   endfunction

   function automatic logic signed [ESU_Z_W-1:0] rand_z();
      if ($urandom_range(0, 15) == 0) return '0;
      return ESU_Z_W'($urandom);
   endfunction

   task automatic load_point();
      send_item(OP_LOAD, rand_coord(), rand_coord(), rand_z(), '0, 1'b0);
   endtask

   initial begin
      int k, m;
      int tol_pick;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: zero tolerance gives an empty window
      send_item(OP_LOAD, 16'sd0, 16'sd0, 24'sd4096, 12'd0, 1'b0);
      send_item(OP_LOAD, 16'sd16, 16'sd0, -24'sd4096, 12'd0, 1'b0);
      send_item(OP_QUERY, '0, '0, '0, 12'd1, 1'b1);
      wait_idle();

      // Directed: widest window, pedestal subtraction, extremes of every field
      csr_write(REG_TOLERANCE, 4095);
      csr_write(REG_PEDESTAL, 1);
      send_item(OP_CLEAR, '0, '0, '0, '0, 1'b0);
      send_item(OP_LOAD, 16'sh7FFF, 16'sh7FFF, 24'sh7FFFFF, 12'hFFF, 1'b1);
      send_item(OP_LOAD, -16'sh8000, -16'sh8000, -24'sh800000, '0, 1'b0);
      send_item(OP_LOAD, 16'sd5, 16'sd5, 24'sd0, '0, 1'b0);  // zero z: not stored
      send_item(OP_UNUSED, 16'shFFFF, 16'shFFFF, 24'shFFFFFF, 12'hFFF, 1'b1);
      send_item(OP_LOAD, 16'sd0, 16'sd0, 24'sd1, '0, 1'b0);
      send_item(OP_QUERY, '0, '0, '0, 12'd0, 1'b1);
      send_item(OP_QUERY, '0, '0, '0, 12'hFFF, 1'b0);
      send_item(OP_QUERY, '0, '0, '0, 12'd2, 1'b0);
      send_item(OP_CLEAR, '0, '0, '0, '0, 1'b0);
      send_item(OP_QUERY, '0, '0, '0, 12'd5, 1'b0);  // empty store, old pedestal
      send_item(OP_QUERY, '0, '0, '0, 12'd5, 1'b1);
      wait_idle();

      // Full store: one load beyond capacity is dropped, one query walks it all
      csr_write(REG_PEDESTAL, 0);
      send_item(OP_CLEAR, '0, '0, '0, '0, 1'b0);
      for (int i = 0; i <= ESU_MAX_POINTS; i++)
         send_item(OP_LOAD, rand_coord(), rand_coord(), ESU_Z_W'($urandom) | 24'd1,
                   '0, 1'b0);
      send_item(OP_QUERY, '0, '0, '0, 12'd7, 1'b1);
      wait_idle();   // sender holds off until every answer is back

      // Random phases of well-formed list sequences with noise mixed in
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent > RANDOM_ITEMS * 4 / 5) idle_on = 1'b0;
         tol_pick = $urandom_range(0, 9);
         if (tol_pick == 0)      csr_write(REG_TOLERANCE, 0);
         else if (tol_pick == 1) csr_write(REG_TOLERANCE, 4095);
         else                    csr_write(REG_TOLERANCE, $urandom_range(1, 12));
         csr_write(REG_PEDESTAL, $urandom_range(0, 1));
         if ($urandom_range(0, 3) != 0) send_item(OP_CLEAR, rand_coord(), rand_coord(),
                                                  rand_z(), ESU_LAG_W'($urandom), 1'b0);
         k = $urandom_range(0, 12);
         for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_item(OP_UNUSED, rand_coord(), rand_coord(), rand_z(),
                         ESU_LAG_W'($urandom), 1'($urandom_range(0, 1)));
            else
               load_point();
         end
         m = $urandom_range(1, 4);
         for (int i = 0; i < m; i++)
            send_item(OP_QUERY, rand_coord(), rand_coord(), rand_z(),
                      $urandom_range(0, 5) == 0 ? ESU_LAG_W'($urandom)
                                                : ESU_LAG_W'($urandom_range(0, 15)),
                      i == 0 ? 1'b1 : ($urandom_range(0, 5) == 0));
         wait_idle();
      end

      // drain, then let the unit settle before the verdict
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("empirical_semivariogram_unit regression: pass");
      else begin
         if (sb.pending() != 0)
            $display("%0t: %0d answers never arrived", $time, sb.pending());
         $display("empirical_semivariogram_unit regression: fail");
      end
      $finish;
   end

endmodule
